### rtl/ffp_pkg.sv
package ffp_pkg;

  localparam int POS_W = 24;
  localparam int LEN_W = 16;
  localparam int END_W = 25;
  localparam int GAP_W = 8;
  localparam int IDX_OUT_W = 5;
  localparam int CNT_OUT_W = 6;

  localparam logic [GAP_W-1:0] MIN_GAP_RESET = 8'd3;

  // read as it travels down the lane chain
  typedef struct packed {
    logic             new_layout;
    logic [POS_W-1:0] left;
    logic [END_W-1:0] new_end;
  } ffp_read_t;

endpackage

### rtl/ffp_ifs.sv
interface ffp_item_if import ffp_pkg::*;;
  logic             valid;
  logic             ready;
  logic             new_layout;
  logic [POS_W-1:0] pos_begin;
  logic [POS_W-1:0] pos_end;
  logic [LEN_W-1:0] gap_count;
  logic [LEN_W-1:0] clear_length;

  modport source (output valid, new_layout, pos_begin, pos_end, gap_count, clear_length,
                  input ready);
  modport sink (input valid, new_layout, pos_begin, pos_end, gap_count, clear_length,
                output ready);
endinterface

interface ffp_result_if import ffp_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [IDX_OUT_W-1:0] lane_index;
  logic                 overflow;
  logic [CNT_OUT_W-1:0] lanes_used;

  modport source (output valid, lane_index, overflow, lanes_used, input ready);
  modport sink (input valid, lane_index, overflow, lanes_used, output ready);
endinterface

interface ffp_cfg_if import ffp_pkg::*;;
  logic             valid;
  logic             ready;
  logic [GAP_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### rtl/ffp_cell.sv
module ffp_cell import ffp_pkg::*; #(
  parameter int LANES = 32,
  parameter int IDX = 0
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic [GAP_W-1:0]             min_gap,
  input  logic                         in_valid,
  input  ffp_read_t                    in_read,
  input  logic                         in_placed,
  input  logic [$clog2(LANES)-1:0]     in_idx,
  input  logic [$clog2(LANES+1)-1:0]   in_count,
  output logic                         out_valid,
  output ffp_read_t                    out_read,
  output logic                         out_placed,
  output logic [$clog2(LANES)-1:0]     out_idx,
  output logic [$clog2(LANES+1)-1:0]   out_count
);

  localparam int IW = $clog2(LANES);
  localparam int CW = $clog2(LANES + 1);

  logic             used;
  logic [END_W-1:0] lane_end;

  logic           eff_used;
  logic           fits;
  logic           take;
  logic           used_next;
  logic [END_W:0] limit;

  always_comb begin
    eff_used  = used & ~in_read.new_layout;
    limit     = {1'b0, lane_end} + {{(END_W + 1 - GAP_W){1'b0}}, min_gap};
    fits      = !eff_used || ({{(END_W + 1 - POS_W){1'b0}}, in_read.left} >= limit);
    take      = in_valid & ~in_placed & fits;
    used_next = eff_used | take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
      if (in_valid) begin
        used <= used_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (take) begin
        lane_end <= in_read.new_end;
      end
      out_read   <= in_read;
      out_placed <= in_placed | take;
      out_idx    <= take ? IW'(IDX) : in_idx;
      out_count  <= in_count + CW'(used_next);
    end
  end

endmodule

### rtl/first_fit_lane_packer.sv
// first-fit lane packer: each read word (begin/end column, gap count, clear
// length) goes to the lowest lane that is empty or whose end plus min_gap is
// at most the read's leftmost column; that lane's end becomes leftmost + gaps
// + length, and one result word (lane, overflow, lanes in use) comes back.
// new_layout empties all lanes ahead of its read. The lanes form a chain of
// LANES cells, one lane per cell; a read steps one cell per cycle while the
// chain advances, so it always sees every earlier read's update. One read
// is accepted every cycle unless the chain stalls; the result word passes the
// input stage, LANES cells and output register before it is offered.
// The chain stalls only when the last cell and the output register both hold
// a word that the sink has not taken. min_gap resets to 3; the user must
// ensure it is written through cfg while no reads are in flight (unchecked).
module first_fit_lane_packer import ffp_pkg::*; #(
  parameter int LANES = 32
) (
  input  logic  clk,
  input  logic  rst,
  ffp_item_if.sink     item,
  ffp_result_if.source result,
  ffp_cfg_if.sink      cfg
);

  localparam int IW = $clog2(LANES);
  localparam int CW = $clog2(LANES + 1);

  // config register
  logic [GAP_W-1:0] min_gap;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_gap <= MIN_GAP_RESET;
    end else if (cfg.valid) begin
      min_gap <= cfg.data;
    end
  end

  // chain links, index k feeds cell k
  logic            link_valid  [LANES+1];
  ffp_read_t       link_read   [LANES+1];
  logic            link_placed [LANES+1];
  logic [IW-1:0]   link_idx    [LANES+1];
  logic [CW-1:0]   link_count  [LANES+1];

  // global advance: hold only when the tail word has nowhere to go
  logic adv;

  assign adv        = !(link_valid[LANES] && result.valid && !result.ready);
  assign item.ready = adv;

  // input stage: leftmost column and the new lane end
  logic [POS_W-1:0] left;

  always_comb begin
    left = (item.pos_begin < item.pos_end) ? item.pos_begin : item.pos_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_valid[0] <= 1'b0;
    end else if (adv) begin
      link_valid[0] <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      link_read[0].new_layout <= item.new_layout;
      link_read[0].left       <= left;
      link_read[0].new_end    <= END_W'(left) + END_W'(item.gap_count)
                                 + END_W'(item.clear_length);
    end
  end

  // fresh words enter the chain unplaced with an empty count
  assign link_placed[0] = 1'b0;
  assign link_idx[0]    = '0;
  assign link_count[0]  = '0;

  // one cell per lane
  for (genvar k = 0; k < LANES; k++) begin : g_lane
    ffp_cell #(
      .LANES (LANES),
      .IDX   (k)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .adv        (adv),
      .min_gap    (min_gap),
      .in_valid   (link_valid[k]),
      .in_read    (link_read[k]),
      .in_placed  (link_placed[k]),
      .in_idx     (link_idx[k]),
      .in_count   (link_count[k]),
      .out_valid  (link_valid[k+1]),
      .out_read   (link_read[k+1]),
      .out_placed (link_placed[k+1]),
      .out_idx    (link_idx[k+1]),
      .out_count  (link_count[k+1])
    );
  end

  // output register, lane index and count masked to field width
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (link_valid[LANES] && adv) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (link_valid[LANES] && adv) begin
      result.lane_index <= IDX_OUT_W'(link_idx[LANES]);
      result.overflow   <= ~link_placed[LANES];
      result.lanes_used <= CNT_OUT_W'(link_count[LANES]);
    end
  end

endmodule

### rtl/ffp_checker.sv
module ffp_checker import ffp_pkg::*; #(
  parameter int LANES = 32
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 res_valid,
  input logic                 res_ready,
  input logic [IDX_OUT_W-1:0] lane_index,
  input logic                 overflow,
  input logic [CNT_OUT_W-1:0] lanes_used
);

  localparam logic [CNT_OUT_W-1:0] LANES_MASKED = CNT_OUT_W'(LANES);
  localparam logic SMALL_CHAIN = (LANES <= 32);

  // a held result word stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result word dropped while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result word offered right after reset");

  a_ovf_idx: assert property (@(posedge clk) disable iff (rst)
    res_valid && overflow |-> lane_index == '0)
    else $error("overflowed read carries a lane index");

  // overflow only once every lane holds a read
  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    res_valid && overflow |-> lanes_used == LANES_MASKED)
    else $error("overflow with free lanes");

  // used lanes form a prefix, so the chosen lane is inside it
  a_prefix: assert property (@(posedge clk) disable iff (rst)
    res_valid && !overflow && SMALL_CHAIN |-> CNT_OUT_W'(lane_index) < lanes_used)
    else $error("chosen lane outside the used lanes");

endmodule

bind first_fit_lane_packer ffp_checker #(
  .LANES (LANES)
) u_ffp_checker (
  .clk        (clk),
  .rst        (rst),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .lane_index (result.lane_index),
  .overflow   (result.overflow),
  .lanes_used (result.lanes_used)
);

### verif/tb_top.sv
module tb_top;
  import ffp_pkg::*;

  localparam int LANES = 32;
  // no-progress limit; the longest correct quiet spell is the sink hold-off
  // plus the lane chain latency, far below this
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam logic [POS_W-1:0] COL_MAX = {POS_W{1'b1}};
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  // one result word as the block reports it
  typedef struct packed {
    logic [IDX_OUT_W-1:0] lane;
    logic                 ovf;
    logic [CNT_OUT_W-1:0] used;
  } placement_t;

  // one row of the directed plan; reps > 1 repeats the same read
  typedef struct {
    logic             nl;
    logic [POS_W-1:0] pb;
    logic [POS_W-1:0] pe;
    logic [LEN_W-1:0] gaps;
    logic [LEN_W-1:0] clen;
    int               reps;
    bit               typed;
    placement_t       want;
  } read_row_t;

  logic clk = 1'b0;
  logic rst;

  ffp_item_if   in_words ();
  ffp_result_if out_words ();
  ffp_cfg_if    gap_port ();

  first_fit_lane_packer #(.LANES(LANES)) u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (in_words),
    .result (out_words),
    .cfg    (gap_port)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the lane file and the gap register
  logic [END_W-1:0] lane_end [LANES];
  bit               lane_busy [LANES];
  logic [GAP_W-1:0] gap_setting;

  placement_t placements_due [$];
  placement_t due_head;
  int mismatch_count = 0;
  int unsigned words_sent = 0;
  int unsigned words_seen = 0;

  // directed reads at the reset gap of 3; typed rows are plain to follow
  // by hand, the others go through the shadow model
  read_row_t plan [17] = '{
    // empty file, zero-length read at column 0 lands in lane 0
    '{1'b1, 24'd0, 24'd0, 16'd0, 16'd0, 1, 1'b1, '{5'd0, 1'b0, 6'd1}},
    // 2 < 0 + 3, so lane 1, which is empty and takes anything
    '{1'b0, 24'd2, 24'd2, 16'd0, 16'd0, 1, 1'b1, '{5'd1, 1'b0, 6'd2}},
    // exactly end + gap fits lane 0
    '{1'b0, 24'd3, 24'd3, 16'd0, 16'd0, 1, 1'b1, '{5'd0, 1'b0, 6'd2}},
    // reverse read, widest fields, leftmost is 0
    '{1'b0, COL_MAX, 24'd0, LEN_MAX, LEN_MAX, 1, 1'b1, '{5'd2, 1'b0, 6'd3}},
    '{1'b0, 24'd0, COL_MAX, 16'd0, 16'd0, 1, 1'b1, '{5'd3, 1'b0, 6'd4}},
    // top column with the largest end sum
    '{1'b0, COL_MAX, COL_MAX, LEN_MAX, LEN_MAX, 1, 1'b1, '{5'd0, 1'b0, 6'd4}},
    '{1'b0, COL_MAX, 24'hFFFFFE, 16'd0, 16'd5, 1, 1'b0, '0},
    '{1'b0, 24'd8, 24'd20, 16'd2, 16'd10, 1, 1'b0, '0},
    // new layout clears everything ahead of its own read
    '{1'b1, COL_MAX, COL_MAX, 16'd0, 16'd0, 1, 1'b1, '{5'd0, 1'b0, 6'd1}},
    '{1'b0, 24'd0, 24'd0, 16'd0, 16'd0, 1, 1'b1, '{5'd1, 1'b0, 6'd2}},
    // fill lanes 2..31
    '{1'b0, 24'd0, 24'd0, 16'd0, 16'd0, 30, 1'b0, '0},
    // every lane taken and none far enough left: overflow
    '{1'b0, 24'd0, 24'd0, LEN_MAX, LEN_MAX, 1, 1'b1, '{5'd0, 1'b1, 6'd32}},
    '{1'b0, 24'd2, 24'd2, 16'd0, 16'd0, 1, 1'b1, '{5'd0, 1'b1, 6'd32}},
    '{1'b0, 24'd3, 24'd7, 16'd1, 16'd1, 1, 1'b0, '0},
    '{1'b1, 24'd0, 24'd0, 16'd0, 16'd0, 1, 1'b1, '{5'd0, 1'b0, 6'd1}},
    '{1'b0, 24'd1, 24'd1, 16'd0, 16'd0, 1, 1'b1, '{5'd1, 1'b0, 6'd2}},
    '{1'b0, 24'd5, 24'd3, 16'd0, 16'd0, 1, 1'b0, '0}
  };

  // first-fit placement of one read into the shadow lane file
  function automatic placement_t place_read(input logic nl, input logic [POS_W-1:0] pb,
                                            input logic [POS_W-1:0] pe,
                                            input logic [LEN_W-1:0] gaps,
                                            input logic [LEN_W-1:0] clen);
    logic [POS_W-1:0] left;
    int chosen;
    int unsigned count;
    placement_t p;
    left = (pb < pe) ? pb : pe;
    chosen = -1;
    count = 0;
    if (nl) begin
      for (int k = 0; k < LANES; k++) begin
        lane_end[k] = '0;
        lane_busy[k] = 1'b0;
      end
    end
    for (int k = 0; k < LANES; k++) begin
      // an empty lane takes the read whatever its stored end says
      if (chosen < 0 && (!lane_busy[k] ||
          32'(left) >= 32'(lane_end[k]) + 32'(gap_setting))) begin
        chosen = k;
      end
    end
    if (chosen >= 0) begin
      lane_busy[chosen] = 1'b1;
      lane_end[chosen] = END_W'(left) + END_W'(gaps) + END_W'(clen);
    end
    for (int k = 0; k < LANES; k++) begin
      if (lane_busy[k]) count++;
    end
    p.lane = (chosen >= 0) ? IDX_OUT_W'(chosen) : '0;
    p.ovf = (chosen < 0);
    p.used = CNT_OUT_W'(count);
    return p;
  endfunction

  // queue the placement for one read word, then offer it until taken
  task automatic offer_read(input logic nl, input logic [POS_W-1:0] pb,
                            input logic [POS_W-1:0] pe, input logic [LEN_W-1:0] gaps,
                            input logic [LEN_W-1:0] clen, input bit typed,
                            input placement_t want);
    placement_t got;
    got = place_read(nl, pb, pe, gaps, clen);
    placements_due.push_back(typed ? want : got);
    // random source gaps, none during the calm stretch
    while (!(words_sent >= 1000 && words_sent < 1300) && $urandom_range(0, 99) < 10) begin
      in_words.valid <= 1'b0;
      @(posedge clk);
    end
    in_words.valid        <= 1'b1;
    in_words.new_layout   <= nl;
    in_words.pos_begin    <= pb;
    in_words.pos_end      <= pe;
    in_words.gap_count    <= gaps;
    in_words.clear_length <= clen;
    @(posedge clk);
    while (!in_words.ready) @(posedge clk);
    words_sent++;
  endtask

  // stop offering and wait until every placement has come back
  task automatic drain_reads();
    in_words.valid <= 1'b0;
    while (placements_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_min_gap(input logic [GAP_W-1:0] value);
    gap_port.valid <= 1'b1;
    gap_port.data  <= value;
    @(posedge clk);
    while (!gap_port.ready) @(posedge clk);
    gap_port.valid <= 1'b0;
    gap_setting = value;
  endtask

  // random layouts: mostly sorted runs of reads opening with a clear, with
  // dense runs that overflow the lane file and sparse runs that reuse lanes;
  // now and then a run skips its clear or steps back, plus raw noise words
  task automatic run_layouts(input int unsigned quota);
    int unsigned done;
    int unsigned reads;
    int unsigned step;
    int unsigned span;
    logic [POS_W:0] cursor;
    logic [POS_W:0] reach;
    logic [POS_W-1:0] left;
    logic [POS_W-1:0] far;
    logic [LEN_W-1:0] gaps;
    logic [LEN_W-1:0] clen;
    logic nl;
    done = 0;
    while (done < quota) begin
      if ($urandom_range(0, 9) == 0) begin
        offer_read(1'($urandom_range(0, 1)), POS_W'($urandom), POS_W'($urandom),
                   LEN_W'($urandom), LEN_W'($urandom), 1'b0, '0);
        done++;
      end else begin
        reads = $urandom_range(4, 70);
        step = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 4) : $urandom_range(0, 400);
        span = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 600);
        // a few runs start near the top of the column range
        if ($urandom_range(0, 7) == 0) cursor = (POS_W+1)'($urandom_range(24'hFF0000, COL_MAX));
        else cursor = (POS_W+1)'($urandom_range(0, 24'hFF0000));
        for (int n = 0; n < reads && done < quota; n++) begin
          left = (cursor > {1'b0, COL_MAX}) ? COL_MAX : cursor[POS_W-1:0];
          // out-of-order read
          if ($urandom_range(0, 19) == 0) begin
            left = (left > 1000) ? left - POS_W'($urandom_range(0, 1000)) : '0;
          end
          clen = LEN_W'($urandom_range(0, span));
          gaps = ($urandom_range(0, 3) == 0) ? LEN_W'($urandom_range(0, 255))
                                             : LEN_W'($urandom_range(0, 3));
          reach = {1'b0, left} + (POS_W+1)'(clen);
          far = (reach > {1'b0, COL_MAX}) ? COL_MAX : reach[POS_W-1:0];
          // a run that forgets its clear continues the previous layout
          nl = (n == 0) && ($urandom_range(0, 19) != 0);
          if ($urandom_range(0, 1) != 0) offer_read(nl, far, left, gaps, clen, 1'b0, '0);
          else offer_read(nl, left, far, gaps, clen, 1'b0, '0);
          cursor = cursor + (POS_W+1)'($urandom_range(0, step));
          done++;
        end
      end
    end
  endtask

  initial begin : stimulus
    logic [GAP_W-1:0] gap_plan [6];
    rst                   <= 1'b1;
    in_words.valid        <= 1'b0;
    in_words.new_layout   <= 1'b0;
    in_words.pos_begin    <= '0;
    in_words.pos_end      <= '0;
    in_words.gap_count    <= '0;
    in_words.clear_length <= '0;
    gap_port.valid        <= 1'b0;
    gap_port.data         <= '0;
    gap_setting = MIN_GAP_RESET;
    for (int k = 0; k < LANES; k++) begin
      lane_end[k] = '0;
      lane_busy[k] = 1'b0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part at the reset gap
    foreach (plan[i]) begin
      for (int r = 0; r < plan[i].reps; r++) begin
        offer_read(plan[i].nl, plan[i].pb, plan[i].pe, plan[i].gaps, plan[i].clen,
                   plan[i].typed, plan[i].want);
      end
    end

    // random part, one gap setting per phase, both extremes included;
    // lanes carry over from phase to phase
    gap_plan = '{8'd0, 8'd255, GAP_W'($urandom_range(4, 254)), 8'd1,
                 GAP_W'($urandom_range(4, 40)), MIN_GAP_RESET};
    foreach (gap_plan[p]) begin
      drain_reads();
      write_min_gap(gap_plan[p]);
      run_layouts(285);
    end
    drain_reads();

    // let the chain run dry and catch any stray result word
    repeat (LANES + 10) @(posedge clk);
    if (mismatch_count == 0 && placements_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // result sink: compare each word taken with the oldest placement due,
  // stall at random, hold off once for a long stretch to back up the chain
  int unsigned hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_words.ready <= 1'b0;
    end else begin
      if (out_words.valid && out_words.ready) begin
        words_seen++;
        if (placements_due.size() == 0) begin
          $error("result word with no placement due: lane_index %0d overflow %0d lanes_used %0d",
                 out_words.lane_index, out_words.overflow, out_words.lanes_used);
          mismatch_count++;
        end else begin
          due_head = placements_due.pop_front();
          if (out_words.lane_index !== due_head.lane) begin
            $error("lane_index: expected %0d, actual %0d", due_head.lane, out_words.lane_index);
            mismatch_count++;
          end
          if (out_words.overflow !== due_head.ovf) begin
            $error("overflow: expected %0d, actual %0d", due_head.ovf, out_words.overflow);
            mismatch_count++;
          end
          if (out_words.lanes_used !== due_head.used) begin
            $error("lanes_used: expected %0d, actual %0d", due_head.used, out_words.lanes_used);
            mismatch_count++;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_words.ready <= 1'b0;
      end else if (!hold_done && words_seen >= 500) begin
        // long hold-off while the source keeps offering
        hold_done = 1'b1;
        hold_left = HOLD_OFF_CYCLES - 1;
        out_words.ready <= 1'b0;
      end else if (words_seen >= 900 && words_seen < 1200) begin
        out_words.ready <= 1'b1;
      end else begin
        out_words.ready <= ($urandom_range(0, 99) >= 10);
      end
    end
  end

  // watchdog on cycles with no word moving on any channel
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_words.valid && in_words.ready) || (out_words.valid && out_words.ready) ||
        (gap_port.valid && gap_port.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

### sim.f
rtl/ffp_pkg.sv
rtl/ffp_ifs.sv
rtl/ffp_cell.sv
rtl/first_fit_lane_packer.sv
rtl/ffp_checker.sv
verif/tb_top.sv
